// File: hw/rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Request and response types and fixed constants for the rotation matrix
// to quaternion converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // Q.28 working format for normalized elements, trace and roots
    localparam int WORK_FRAC  = 28;
    localparam int NORM_GUARD = 16;

    typedef struct packed {
        logic signed [15:0] r1c1;
        logic signed [15:0] r1c2;
        logic signed [15:0] r1c3;
        logic signed [15:0] r2c1;
        logic signed [15:0] r2c2;
        logic signed [15:0] r2c3;
        logic signed [15:0] r3c1;
        logic signed [15:0] r3c2;
        logic signed [15:0] r3c3;
    } t_rmq_req;

    typedef struct packed {
        logic signed [15:0] q_real;
        logic signed [15:0] q_i;
        logic signed [15:0] q_j;
        logic signed [15:0] q_k;
        logic               degenerate;
    } t_rmq_rsp;

endpackage

// File: hw/rtl/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, floor(sqrt(i_rad)), one result bit per
// register stage. A tag travels alongside each radicand.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
    parameter int IN_W  = 64,
    parameter int TAG_W = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [IN_W-1:0]       i_rad,
    input  logic [TAG_W-1:0]      i_tag,
    output logic                  o_valid,
    output logic [IN_W/2-1:0]     o_root,
    output logic [TAG_W-1:0]      o_tag
);

    localparam int OUT_W = IN_W / 2;

    logic [OUT_W:0]   w_rem [0:OUT_W];
    logic [OUT_W-1:0] w_res [0:OUT_W];
    logic [IN_W-1:0]  w_rad [0:OUT_W];
    logic             w_v   [0:OUT_W];
    logic [TAG_W-1:0] w_tag [0:OUT_W];

    assign w_rem[0] = '0;
    assign w_res[0] = '0;
    assign w_rad[0] = i_rad;
    assign w_v[0]   = i_valid;
    assign w_tag[0] = i_tag;

    for (genvar s = 0; s < OUT_W; s++) begin : g_stage
        logic [OUT_W+2:0] cand;
        logic [OUT_W+2:0] trial;
        logic             ge;
        logic [OUT_W:0]   r_rem;
        logic [OUT_W-1:0] r_res;
        logic [IN_W-1:0]  r_rad;
        logic             r_v;
        logic [TAG_W-1:0] r_tag;

        // bring down the next two radicand bits and try the next root bit
        always_comb begin
            cand  = {w_rem[s], w_rad[s][IN_W-1 -: 2]};
            trial = {1'b0, w_res[s], 2'b01};
            ge    = (cand >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= ge ? (OUT_W+1)'(cand - trial) : (OUT_W+1)'(cand);
                r_res <= {w_res[s][OUT_W-2:0], ge};
                r_rad <= w_rad[s] << 2;
                r_tag <= w_tag[s];
            end
        end

        assign w_rem[s+1] = r_rem;
        assign w_res[s+1] = r_res;
        assign w_rad[s+1] = r_rad;
        assign w_v[s+1]   = r_v;
        assign w_tag[s+1] = r_tag;
    end

    assign o_valid = w_v[OUT_W];
    assign o_root  = w_res[OUT_W];
    assign o_tag   = w_tag[OUT_W];

endmodule

// File: hw/rtl/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divider, one quotient bit per register stage.
// The numerator must be below i_den << Q_W; the quotient is floored.
// ----------------------------------------------------------------------------
module rmq_div #(
    parameter int N_W   = 60,
    parameter int D_W   = 32,
    parameter int Q_W   = 29,
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [N_W-1:0]   i_num,
    input  logic [D_W-1:0]   i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [Q_W-1:0]   o_quot,
    output logic [TAG_W-1:0] o_tag
);

    localparam int CW = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

    logic [N_W-1:0]   w_rem [0:Q_W];
    logic [D_W-1:0]   w_den [0:Q_W];
    logic [Q_W-1:0]   w_q   [0:Q_W];
    logic             w_v   [0:Q_W];
    logic [TAG_W-1:0] w_tag [0:Q_W];

    assign w_rem[0] = i_num;
    assign w_den[0] = i_den;
    assign w_q[0]   = '0;
    assign w_v[0]   = i_valid;
    assign w_tag[0] = i_tag;

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        localparam int K = Q_W - 1 - s;
        logic [CW-1:0]    shifted;
        logic [CW-1:0]    rem_x;
        logic             ge;
        logic [N_W-1:0]   r_rem;
        logic [D_W-1:0]   r_den;
        logic [Q_W-1:0]   r_q;
        logic             r_v;
        logic [TAG_W-1:0] r_tag;

        always_comb begin
            shifted = CW'(w_den[s]) << K;
            rem_x   = CW'(w_rem[s]);
            ge      = (rem_x >= shifted);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= ge ? N_W'(rem_x - shifted) : w_rem[s];
                r_den <= w_den[s];
                r_q   <= {w_q[s][Q_W-2:0], ge};
                r_tag <= w_tag[s];
            end
        end

        assign w_rem[s+1] = r_rem;
        assign w_den[s+1] = r_den;
        assign w_q[s+1]   = r_q;
        assign w_v[s+1]   = r_v;
        assign w_tag[s+1] = r_tag;
    end

    assign o_valid = w_v[Q_W];
    assign o_quot  = w_q[Q_W];
    assign o_tag   = w_tag[Q_W];

endmodule

// File: hw/rtl/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation matrix in Q4.12 into a saturated Q1.14 quaternion.
// ----------------------------------------------------------------------------
// One request per clock enters while o_stall is low, and one response per
// clock leaves while i_stall is low. The depth is set by the bit-serial
// stages: a 32-stage row-length root, a 29-stage normalizing divide (nine
// lanes), a 30-stage quaternion root and a 17-stage component divide (three
// lanes), plus seven stages of squaring, summing, trace selection, rounding
// and output. Rows are scaled to unit length first, then the trace or
// largest-diagonal formula is applied. A row of zero length gives a zero
// quaternion with degenerate set. A two-entry output stage lets the pipeline
// keep flowing for one request after the consumer stalls.
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_rmq_req i_req,
    output logic     o_valid,
    input  logic     i_stall,
    output t_rmq_rsp o_rsp
);

    localparam int NUM_W = 30 + OUT_FRAC_BITS + 1;
    localparam int OVF_W = (NUM_W > 48) ? NUM_W : 48;
    localparam int NRM_W = 16 + WORK_FRAC + NORM_GUARD;

    localparam logic [1:0] SEL_TR = 2'd0;
    localparam logic [1:0] SEL_X  = 2'd1;
    localparam logic [1:0] SEL_Y  = 2'd2;
    localparam logic [1:0] SEL_Z  = 2'd3;

    localparam logic signed [31:0] WORK_ONE = 32'sd1 <<< WORK_FRAC;

    logic en;
    logic r_ov, r_sv;
    t_rmq_rsp r_o, r_s;

    assign en = !r_sv;

    // ---------------- stage A: capture request
    logic signed [15:0] w_in [0:8];
    logic signed [15:0] r_a [0:8];
    logic               r_av;

    assign w_in[0] = i_req.r1c1;
    assign w_in[1] = i_req.r1c2;
    assign w_in[2] = i_req.r1c3;
    assign w_in[3] = i_req.r2c1;
    assign w_in[4] = i_req.r2c2;
    assign w_in[5] = i_req.r2c3;
    assign w_in[6] = i_req.r3c1;
    assign w_in[7] = i_req.r3c2;
    assign w_in[8] = i_req.r3c3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
        end else if (en) begin
            r_av <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= w_in;
        end
    end

    // ---------------- stage B: squares
    logic [30:0]        r_sq [0:8];
    logic signed [15:0] r_ba [0:8];
    logic               r_bv;
    logic signed [31:0] w_prod [0:8];

    for (genvar e = 0; e < 9; e++) begin : g_sq
        assign w_prod[e] = 32'(r_a[e]) * 32'(r_a[e]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= 1'b0;
        end else if (en) begin
            r_bv <= r_av;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int e = 0; e < 9; e++) begin
                r_sq[e] <= w_prod[e][30:0];
            end
            r_ba <= r_a;
        end
    end

    // ---------------- stage C: squared row lengths
    logic [31:0]        r_len [0:2];
    logic signed [15:0] r_ca [0:8];
    logic               r_cv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 1'b0;
        end else if (en) begin
            r_cv <= r_bv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                r_len[r] <= 32'(r_sq[3*r]) + 32'(r_sq[3*r+1]) + 32'(r_sq[3*r+2]);
            end
            r_ca <= r_ba;
        end
    end

    // ---------------- row length roots
    logic [31:0] w_s  [0:2];
    logic [48:0] w_st [0:2];
    logic        w_sv [0:2];

    for (genvar r = 0; r < 3; r++) begin : g_rowsqrt
        rmq_sqrt #(
            .IN_W  (64),
            .TAG_W (49)
        ) u_sqrt (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (r_cv),
            .i_rad   ({r_len[r], 32'd0}),
            .i_tag   ({(r_len[r] == 32'd0), r_ca[3*r], r_ca[3*r+1], r_ca[3*r+2]}),
            .o_valid (w_sv[r]),
            .o_root  (w_s[r]),
            .o_tag   (w_st[r])
        );
    end

    // ---------------- normalizing divides, one lane per element
    logic [28:0] w_nq [0:8];
    logic [1:0]  w_nt [0:8];
    logic        w_nv [0:8];

    for (genvar e = 0; e < 9; e++) begin : g_norm
        localparam int ROW = e / 3;
        localparam int COL = e % 3;
        logic signed [15:0] elem;
        logic [15:0]        mag;

        assign elem = w_st[ROW][47-16*COL -: 16];
        assign mag  = elem[15] ? 16'(-elem) : 16'(elem);

        rmq_div #(
            .N_W   (NRM_W),
            .D_W   (32),
            .Q_W   (29),
            .TAG_W (2)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_sv[ROW]),
            .i_num   ({mag, {(WORK_FRAC+NORM_GUARD){1'b0}}}),
            .i_den   (w_s[ROW]),
            .i_tag   ({w_st[ROW][48], elem[15]}),
            .o_valid (w_nv[e]),
            .o_quot  (w_nq[e]),
            .o_tag   (w_nt[e])
        );
    end

    // ---------------- stage D: signed normalized elements
    logic signed [29:0] r_m [0:8];
    logic               r_dv;
    logic               r_ddeg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else if (en) begin
            r_dv <= w_nv[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int e = 0; e < 9; e++) begin
                // clamp magnitude to 1.0, then restore the sign
                if (w_nq[e] > (29'd1 << WORK_FRAC)) begin
                    r_m[e] <= w_nt[e][0] ? -(30'sd1 <<< WORK_FRAC) : (30'sd1 <<< WORK_FRAC);
                end else begin
                    r_m[e] <= w_nt[e][0] ? 30'(-{1'b0, w_nq[e]}) : 30'({1'b0, w_nq[e]});
                end
            end
            r_ddeg <= w_nt[0][1] | w_nt[3][1] | w_nt[6][1];
        end
    end

    // ---------------- stage E: trace, branch and root argument
    logic signed [31:0] tr;
    logic signed [31:0] m32 [0:8];
    logic signed [31:0] arg;
    logic signed [31:0] num32 [0:2];
    logic [1:0]         sel;
    logic [30:0]        r_earg;
    logic signed [30:0] r_en [0:2];
    logic [1:0]         r_esel;
    logic               r_edeg;
    logic               r_ev;

    always_comb begin
        for (int e = 0; e < 9; e++) begin
            m32[e] = 32'(r_m[e]);
        end
        tr = m32[0] + m32[4] + m32[8];
        if (tr > 32'sd0) begin
            sel      = SEL_TR;
            arg      = tr + WORK_ONE;
            num32[0] = m32[7] - m32[5];
            num32[1] = m32[2] - m32[6];
            num32[2] = m32[3] - m32[1];
        end else if (m32[0] > m32[4] && m32[0] > m32[8]) begin
            sel      = SEL_X;
            arg      = WORK_ONE + m32[0] - m32[4] - m32[8];
            num32[0] = m32[7] - m32[5];
            num32[1] = m32[1] + m32[3];
            num32[2] = m32[2] + m32[6];
        end else if (m32[4] > m32[8]) begin
            sel      = SEL_Y;
            arg      = WORK_ONE + m32[4] - m32[0] - m32[8];
            num32[0] = m32[2] - m32[6];
            num32[1] = m32[1] + m32[3];
            num32[2] = m32[5] + m32[7];
        end else begin
            sel      = SEL_Z;
            arg      = WORK_ONE + m32[8] - m32[0] - m32[4];
            num32[0] = m32[3] - m32[1];
            num32[1] = m32[2] + m32[6];
            num32[2] = m32[5] + m32[7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= 1'b0;
        end else if (en) begin
            r_ev <= r_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // a non-positive argument gives a zero root
            r_earg <= (arg > 32'sd0) ? arg[30:0] : 31'd0;
            for (int j = 0; j < 3; j++) begin
                r_en[j] <= num32[j][30:0];
            end
            r_esel <= sel;
            r_edeg <= r_ddeg;
        end
    end

    // ---------------- quaternion root
    logic [29:0] w_root;
    logic [95:0] w_rt;
    logic        w_rv;

    rmq_sqrt #(
        .IN_W  (60),
        .TAG_W (96)
    ) u_qsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_ev),
        .i_rad   ({1'b0, r_earg, {WORK_FRAC{1'b0}}}),
        .i_tag   ({r_edeg, r_esel, r_en[0], r_en[1], r_en[2]}),
        .o_valid (w_rv),
        .o_root  (w_root),
        .o_tag   (w_rt)
    );

    // ---------------- stage F: dividend setup, overflow check, half term
    logic [NUM_W-1:0] numv [0:2];
    logic             nneg [0:2];
    logic             novf [0:2];
    logic [30:0]      den;
    logic [NUM_W-1:0] hsum;
    logic [NUM_W-1:0] hq;
    logic [15:0]      hsat;

    logic [NUM_W-1:0] r_fn [0:2];
    logic [30:0]      r_fd;
    logic             r_fs [0:2];
    logic             r_fo [0:2];
    logic             r_fz;
    logic [15:0]      r_fh;
    logic [1:0]       r_fsel;
    logic             r_fdeg;
    logic             r_fv;

    always_comb begin
        logic signed [30:0] n;
        logic [29:0]        mag;
        den = {w_root, 1'b0};
        for (int j = 0; j < 3; j++) begin
            n       = w_rt[92-31*j -: 31];
            mag     = n[30] ? 30'(-n) : n[29:0];
            nneg[j] = n[30];
            numv[j] = NUM_W'({mag, {OUT_FRAC_BITS{1'b0}}}) + NUM_W'(w_root);
            novf[j] = (OVF_W'(numv[j]) >= (OVF_W'(den) << 17));
        end
        // root / 2 into the output format, rounded half up
        hsum = NUM_W'({w_root, {OUT_FRAC_BITS{1'b0}}}) + (NUM_W'(1) << WORK_FRAC);
        hq   = hsum >> (WORK_FRAC + 1);
        hsat = (hq > NUM_W'(32767)) ? 16'd32767 : hq[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (en) begin
            r_fv <= w_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                // drop the dividend when the result saturates or the root is zero
                r_fn[j] <= (novf[j] || w_root == 30'd0) ? '0 : numv[j];
                r_fs[j] <= nneg[j];
                r_fo[j] <= novf[j];
            end
            r_fd   <= den;
            r_fz   <= (w_root == 30'd0);
            r_fh   <= hsat;
            r_fsel <= w_rt[94:93];
            r_fdeg <= w_rt[95];
        end
    end

    // ---------------- component divides
    logic [16:0] w_dq [0:2];
    logic [21:0] w_dt [0:2];
    logic        w_dv [0:2];

    for (genvar j = 0; j < 3; j++) begin : g_qdiv
        logic [18:0] extra;
        assign extra = (j == 0) ? {r_fdeg, r_fsel, r_fh} : 19'd0;

        rmq_div #(
            .N_W   (NUM_W),
            .D_W   (31),
            .Q_W   (17),
            .TAG_W (22)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (r_fv),
            .i_num   (r_fn[j]),
            .i_den   (r_fd),
            .i_tag   ({r_fs[j], r_fo[j], r_fz, extra}),
            .o_valid (w_dv[j]),
            .o_quot  (w_dq[j]),
            .o_tag   (w_dt[j])
        );
    end

    // ---------------- stage G: saturate, place components
    logic signed [15:0] qs [0:2];
    t_rmq_rsp           rsp;
    logic               push;

    always_comb begin
        logic [1:0]         hsel;
        logic signed [15:0] half;
        for (int j = 0; j < 3; j++) begin
            if (w_dt[j][19]) begin
                qs[j] = 16'sd0;
            end else if (w_dt[j][21]) begin
                qs[j] = (w_dt[j][20] || w_dq[j] > 17'd32768) ? -16'sd32768
                                                              : 16'(-{1'b0, w_dq[j]});
            end else begin
                qs[j] = (w_dt[j][20] || w_dq[j] > 17'd32767) ? 16'sd32767 : w_dq[j][15:0];
            end
        end
        hsel = w_dt[0][17:16];
        half = w_dt[0][15:0];
        unique case (hsel)
            SEL_TR: begin
                rsp.q_real = half;  rsp.q_i = qs[0]; rsp.q_j = qs[1]; rsp.q_k = qs[2];
            end
            SEL_X: begin
                rsp.q_real = qs[0]; rsp.q_i = half;  rsp.q_j = qs[1]; rsp.q_k = qs[2];
            end
            SEL_Y: begin
                rsp.q_real = qs[0]; rsp.q_i = qs[1]; rsp.q_j = half;  rsp.q_k = qs[2];
            end
            default: begin
                rsp.q_real = qs[0]; rsp.q_i = qs[1]; rsp.q_j = qs[2]; rsp.q_k = half;
            end
        endcase
        rsp.degenerate = w_dt[0][18];
        if (w_dt[0][18]) begin
            rsp.q_real = 16'sd0;
            rsp.q_i    = 16'sd0;
            rsp.q_j    = 16'sd0;
            rsp.q_k    = 16'sd0;
        end
    end

    assign push = en && w_dv[0];

    // ---------------- output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (r_sv) begin
                if (!i_stall) begin
                    r_sv <= 1'b0;
                end
            end else if (push) begin
                if (r_ov && i_stall) begin
                    r_sv <= 1'b1;
                end else begin
                    r_ov <= 1'b1;
                end
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (!i_stall) begin
                r_o <= r_s;
            end
        end else if (push) begin
            if (r_ov && i_stall) begin
                r_s <= rsp;
            end else begin
                r_o <= rsp;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_rsp   = r_o;
    assign o_stall = r_sv;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid entry holds a response while the output is empty");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.degenerate) |->
        (o_rsp.q_real == 16'sd0 && o_rsp.q_i == 16'sd0 &&
         o_rsp.q_j == 16'sd0 && o_rsp.q_k == 16'sd0))
        else $error("degenerate response with nonzero quaternion");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sv) |-> $past(r_ov && i_stall && w_dv[0]))
        else $error("skid entry filled without a stalled output and a new response");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_nv[1] == w_nv[0] && w_nv[2] == w_nv[0] && w_nv[3] == w_nv[0] &&
         w_nv[4] == w_nv[0] && w_nv[5] == w_nv[0] && w_nv[6] == w_nv[0] &&
         w_nv[7] == w_nv[0] && w_nv[8] == w_nv[0] &&
         w_dv[1] == w_dv[0] && w_dv[2] == w_dv[0]))
        else $error("divider lanes out of step");
`endif

endmodule
